// ===== src/crf_pkg.sv =====
// Shared types, widths and codes for the circle ring and fill overlay.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package crf_pkg;

  // Default image extent for the in-range check on pixel coordinates
  localparam int MAX_DIM_DEF = 4096;

  // Field widths
  localparam int COORD_W    = 12;
  localparam int CENTER_W   = 16;
  localparam int DIFF_W     = CENTER_W + 1;
  localparam int SQ_W       = 32;
  localparam int LEN_W      = 12;
  localparam int HALF_W     = LEN_W - 1;
  localparam int BOUND_W    = LEN_W + 1;
  localparam int OUTER_SQ_W = 2 * BOUND_W;
  localparam int INNER_SQ_W = 2 * LEN_W;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 3 * CH_W;
  localparam int REGION_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  typedef enum logic [REGION_W-1:0] {
    REGION_NONE = 2'd0,
    REGION_FILL = 2'd1,
    REGION_RING = 2'd2
  } region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X       = 3'd0,
    CFG_CENTER_Y       = 3'd1,
    CFG_RADIUS         = 3'd2,
    CFG_THICKNESS      = 3'd3,
    CFG_FILL_ENABLE    = 3'd4,
    CFG_LINE_COLOR     = 3'd5,
    CFG_INTERIOR_COLOR = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic [LEN_W-1:0]           radius;
    logic [LEN_W-1:0]           thickness;
    logic                       fill_enable;
    logic [COLOR_W-1:0]         line_color;
    logic [COLOR_W-1:0]         interior_color;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // One beat leaving the distance pipeline
  typedef struct packed {
    logic                  valid;
    logic                  in_range;
    logic [SQ_W-1:0]       d2;
    logic [OUTER_SQ_W-1:0] outer_sq;
    logic [INNER_SQ_W-1:0] inner_sq;
    rgb_t                  pix;
  } dist_beat_t;

endpackage

// ===== src/circle_ring_fill_overlay_core.sv =====
// Top level of the thick circle ring and fill overlay.
// Depends on crf_pkg, crf_cfg_regs, crf_dist_pipe and crf_classify.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   pixel in | start, busy         | pixel_x_i, pixel_y_i, in_red/green/blue_i
//   result   | res_valid_o strobe  | out_red/green/blue_o, region_o
//   config   | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// One pixel enters every cycle; busy stays low. Each result passes through
// the four register stages (difference, square, sum, compare) after its
// beat is taken. Reset clears the valid bits and loads the register
// defaults. The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps

module circle_ring_fill_overlay_core #(
  parameter int MAX_DIM = crf_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [crf_pkg::COORD_W-1:0]    pixel_x_i,
  input  logic [crf_pkg::COORD_W-1:0]    pixel_y_i,
  input  logic [crf_pkg::CH_W-1:0]       in_red_i,
  input  logic [crf_pkg::CH_W-1:0]       in_green_i,
  input  logic [crf_pkg::CH_W-1:0]       in_blue_i,
  output logic                           res_valid_o,
  output logic [crf_pkg::CH_W-1:0]       out_red_o,
  output logic [crf_pkg::CH_W-1:0]       out_green_o,
  output logic [crf_pkg::CH_W-1:0]       out_blue_o,
  output logic [crf_pkg::REGION_W-1:0]   region_o,
  input  logic                           cfg_we_i,
  input  logic [crf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import crf_pkg::*;

  cfg_t       cfg;
  rgb_t       in_pix, out_pix;
  dist_beat_t beat;
  logic       accept;

  // Take a beat whenever start is high
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign in_pix = '{red: in_red_i, green: in_green_i, blue: in_blue_i};

  crf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  crf_dist_pipe #(
    .MAX_DIM (MAX_DIM)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .pix_i     (in_pix),
    .cfg_i     (cfg),
    .beat_o    (beat)
  );

  crf_classify u_cls (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (beat),
    .cfg_i    (cfg),
    .valid_o  (res_valid_o),
    .pix_o    (out_pix),
    .region_o (region_o)
  );

  assign out_red_o   = out_pix.red;
  assign out_green_o = out_pix.green;
  assign out_blue_o  = out_pix.blue;

`ifndef SYNTHESIS
  // A result strobe always traces back to a taken input beat
  a_valid_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, 4))
    else $error("result strobe without a matching input beat");

  // An untouched pixel leaves with the color it came in with
  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && region_o == REGION_NONE) |->
      (out_red_o == $past(in_red_i, 4) && out_green_o == $past(in_green_i, 4)
       && out_blue_o == $past(in_blue_i, 4)))
    else $error("untouched pixel changed color");
`endif

endmodule

// ===== src/crf_cfg_regs.sv =====
// Configuration register file for the overlay: center, radius, thickness,
// fill enable and the two colors. Depends on crf_pkg.
`timescale 1ns / 1ps

module crf_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output crf_pkg::cfg_t                  cfg_o
);
  import crf_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write and update one register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X:       cfg_d.center_x       = signed'(cfg_data_i[CENTER_W-1:0]);
        CFG_CENTER_Y:       cfg_d.center_y       = signed'(cfg_data_i[CENTER_W-1:0]);
        CFG_RADIUS:         cfg_d.radius         = cfg_data_i[LEN_W-1:0];
        CFG_THICKNESS:      cfg_d.thickness      = cfg_data_i[LEN_W-1:0];
        CFG_FILL_ENABLE:    cfg_d.fill_enable    = cfg_data_i[0];
        CFG_LINE_COLOR:     cfg_d.line_color     = cfg_data_i[COLOR_W-1:0];
        CFG_INTERIOR_COLOR: cfg_d.interior_color = cfg_data_i[COLOR_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x       <= '0;
      cfg_q.center_y       <= '0;
      cfg_q.radius         <= LEN_W'(1);
      cfg_q.thickness      <= LEN_W'(1);
      cfg_q.fill_enable    <= 1'b0;
      cfg_q.line_color     <= '0;
      cfg_q.interior_color <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/crf_dist_pipe.sv =====
// Three-stage squared-distance pipeline: differences and ring bounds,
// squares, then the sum. Depends on crf_pkg.
`timescale 1ns / 1ps

module crf_dist_pipe #(
  parameter int MAX_DIM = crf_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [crf_pkg::COORD_W-1:0] pixel_x_i,
  input  logic [crf_pkg::COORD_W-1:0] pixel_y_i,
  input  crf_pkg::rgb_t               pix_i,
  input  crf_pkg::cfg_t               cfg_i,
  output crf_pkg::dist_beat_t         beat_o
);
  import crf_pkg::*;

  localparam int PAD_W = DIFF_W - COORD_W;

  // Stage 1: coordinate differences, in-range flag, ring bounds
  logic                     s1_valid_q;
  logic                     s1_in_range_q;
  logic signed [DIFF_W-1:0] s1_dx_q, s1_dy_q, s1_dx_d, s1_dy_d;
  logic [BOUND_W-1:0]       s1_outer_q, s1_outer_d;
  logic [LEN_W-1:0]         s1_inner_q, s1_inner_d;
  logic [HALF_W-1:0]        half_thick;
  logic                     in_range_d;
  rgb_t                     s1_pix_q;

  always_comb begin
    s1_dx_d    = signed'({{PAD_W{1'b0}}, pixel_x_i})
               - signed'({cfg_i.center_x[CENTER_W-1], cfg_i.center_x});
    s1_dy_d    = signed'({{PAD_W{1'b0}}, pixel_y_i})
               - signed'({cfg_i.center_y[CENTER_W-1], cfg_i.center_y});
    half_thick = cfg_i.thickness[LEN_W-1:1];
    s1_outer_d = {1'b0, cfg_i.radius} + {2'b00, half_thick};
    // Clamp the inner bound at zero when the half width exceeds the radius
    s1_inner_d = (cfg_i.radius > {1'b0, half_thick})
               ? cfg_i.radius - {1'b0, half_thick} : '0;
    in_range_d = (32'(pixel_x_i) < 32'(MAX_DIM)) && (32'(pixel_y_i) < 32'(MAX_DIM));
  end

  // Stage 2: squares
  logic                         s2_valid_q;
  logic                         s2_in_range_q;
  logic signed [2*DIFF_W-1:0]   sq_x_full, sq_y_full;
  logic [SQ_W-1:0]              s2_sq_x_q, s2_sq_y_q;
  logic [OUTER_SQ_W-1:0]        s2_outer_sq_q, s2_outer_sq_d;
  logic [INNER_SQ_W-1:0]        s2_inner_sq_q, s2_inner_sq_d;
  rgb_t                         s2_pix_q;

  always_comb begin
    sq_x_full     = (2*DIFF_W)'(s1_dx_q) * (2*DIFF_W)'(s1_dx_q);
    sq_y_full     = (2*DIFF_W)'(s1_dy_q) * (2*DIFF_W)'(s1_dy_q);
    s2_outer_sq_d = OUTER_SQ_W'(s1_outer_q) * OUTER_SQ_W'(s1_outer_q);
    s2_inner_sq_d = INNER_SQ_W'(s1_inner_q) * INNER_SQ_W'(s1_inner_q);
  end

  // Stage 3: sum of squares
  logic [SQ_W-1:0]       s3_d2_d;
  logic                  s3_valid_q;
  logic                  s3_in_range_q;
  logic [SQ_W-1:0]       s3_d2_q;
  logic [OUTER_SQ_W-1:0] s3_outer_sq_q;
  logic [INNER_SQ_W-1:0] s3_inner_sq_q;
  rgb_t                  s3_pix_q;

  assign s3_d2_d = s2_sq_x_q + s2_sq_y_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    s1_in_range_q <= in_range_d;
    s1_dx_q       <= s1_dx_d;
    s1_dy_q       <= s1_dy_d;
    s1_outer_q    <= s1_outer_d;
    s1_inner_q    <= s1_inner_d;
    s1_pix_q      <= pix_i;

    s2_in_range_q <= s1_in_range_q;
    s2_sq_x_q     <= sq_x_full[SQ_W-1:0];
    s2_sq_y_q     <= sq_y_full[SQ_W-1:0];
    s2_outer_sq_q <= s2_outer_sq_d;
    s2_inner_sq_q <= s2_inner_sq_d;
    s2_pix_q      <= s1_pix_q;

    s3_in_range_q <= s2_in_range_q;
    s3_d2_q       <= s3_d2_d;
    s3_outer_sq_q <= s2_outer_sq_q;
    s3_inner_sq_q <= s2_inner_sq_q;
    s3_pix_q      <= s2_pix_q;
  end

  assign beat_o = '{valid:    s3_valid_q,
                    in_range: s3_in_range_q,
                    d2:       s3_d2_q,
                    outer_sq: s3_outer_sq_q,
                    inner_sq: s3_inner_sq_q,
                    pix:      s3_pix_q};

endmodule

// ===== src/crf_classify.sv =====
// Final stage: compare the squared distance to the ring bounds, pick the
// color and register the result beat. Depends on crf_pkg.
`timescale 1ns / 1ps

module crf_classify (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  crf_pkg::dist_beat_t            beat_i,
  input  crf_pkg::cfg_t                  cfg_i,
  output logic                           valid_o,
  output crf_pkg::rgb_t                  pix_o,
  output logic [crf_pkg::REGION_W-1:0]   region_o
);
  import crf_pkg::*;

  logic    on_ring, in_disc;
  rgb_t    pix_d, pix_q;
  region_e region_d, region_q;
  logic    valid_q;

  // Classify and select the color; the ring wins over the fill
  always_comb begin
    on_ring  = (beat_i.d2 >= SQ_W'(beat_i.inner_sq)) && (beat_i.d2 <= SQ_W'(beat_i.outer_sq));
    in_disc  = beat_i.d2 <= SQ_W'(beat_i.inner_sq);
    pix_d    = beat_i.pix;
    region_d = REGION_NONE;
    priority if (!beat_i.in_range) begin
      region_d = REGION_NONE;
    end else if (on_ring) begin
      region_d = REGION_RING;
      pix_d    = cfg_i.line_color;
    end else if (cfg_i.fill_enable && in_disc) begin
      region_d = REGION_FILL;
      pix_d    = cfg_i.interior_color;
    end else begin
      region_d = REGION_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    region_q <= region_d;
  end

  assign valid_o  = valid_q;
  assign pix_o    = pix_q;
  assign region_o = region_q;

endmodule
